>>> sv/assert_macros.svh
// assertion macros used by the top rtl file of the decision window entropy block
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define DWE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dwe assertion failed");

// next-cycle implication, checked outside reset
`define DWE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dwe assertion failed");

`endif

>>> sv/dwe_pkg.sv
// types, constants and the log2 helper for the decision window entropy block
// no dependencies
package dwe_pkg;

    localparam int NUM_CLASSES = 10;
    localparam int CLS_W       = 4;
    localparam int CNT_OUT_W   = 6;
    localparam int ENT_W       = 18;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_LOOKUP,
        ST_DONE
    } dwe_state_t;

    typedef struct packed {
        logic capture;
        logic apply;
        logic lookup;
        logic load;
    } dwe_cmd_t;

    typedef struct packed {
        logic out_free;
    } dwe_stat_t;

    // log2 in unsigned fixed point, 32 fraction bits, by repeated squaring
    // only evaluated at elaboration to build the term table
    function automatic logic [63:0] dwe_log2_q32(input logic [31:0] x);
        logic [63:0] k;
        logic [63:0] m;
        logic [63:0] frac;
        k    = '0;
        frac = '0;
        for (int i = 0; i < 31; i++)
        begin
            if ((x >> (i + 1)) != 32'd0)
                k = 64'(i + 1);
        end
        m = 64'(x) << (64'd30 - k);
        for (int i = 0; i < 32; i++)
        begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31))
            begin
                frac = frac | 64'd1;
                m    = m >> 1;
            end
        end
        return (k << 32) | frac;
    endfunction

endpackage

>>> sv/dwe_if.sv
// channel interfaces of the decision window entropy block
// depends on dwe_pkg for field widths
interface dwe_item_if
    import dwe_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             mode;
    logic [CLS_W-1:0] decision;

    modport source (output valid, output mode, output decision, input ready);
    modport sink (input valid, input mode, input decision, output ready);
endinterface

interface dwe_result_if
    import dwe_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 accepted;
    logic [CLS_W-1:0]     popped_value;
    logic [CNT_OUT_W-1:0] entry_count;
    logic                 is_full;
    logic                 is_empty;
    logic [ENT_W-1:0]     window_entropy;

    modport source (output valid, output accepted, output popped_value,
                    output entry_count, output is_full, output is_empty,
                    output window_entropy, input ready);
    modport sink (input valid, input accepted, input popped_value,
                  input entry_count, input is_full, input is_empty,
                  input window_entropy, output ready);
endinterface

>>> sv/decision_window_entropy_unit.sv
// queue of class decisions with histogram and windowed entropy
// a push or pop beat enters on item and one beat leaves on result per item
// channels: item carries mode (0 push, 1 pop) and decision; result carries
//   accepted, popped_value, entry_count, is_full, is_empty, window_entropy
// each item goes from accept to a result beat in these steps: capture with the
//   entry ram read, histogram and pointer update, term table lookup, then the
//   output register load; a new item is taken only after the last one's load
// the entropy sum is kept running, so only the one class that moved is looked up
// the queue holds at most DEPTH-1 entries; a push to a full queue or of a
//   decision above nine is refused, a pop from an empty queue returns zero
// reset empties the queue, clears the histogram and the entropy sum at once
// a stalled result waits in the output register; the next item is taken and
//   worked on meanwhile, and its load waits until the held beat leaves
// depends on dwe_pkg, dwe_if, dwe_ram, dwe_ctrl, dwe_datapath
`include "assert_macros.svh"

module decision_window_entropy_unit
    import dwe_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    dwe_item_if.sink     item,
    dwe_result_if.source result
);
    dwe_cmd_t  cmd;
    dwe_stat_t stat;
    logic      item_ready;

    dwe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    dwe_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .in_mode            (item.mode),
        .in_decision        (item.decision),
        .out_valid          (result.valid),
        .out_ready          (result.ready),
        .out_accepted       (result.accepted),
        .out_popped_value   (result.popped_value),
        .out_entry_count    (result.entry_count),
        .out_is_full        (result.is_full),
        .out_is_empty       (result.is_empty),
        .out_window_entropy (result.window_entropy)
    );

    assign item.ready = item_ready;

    `DWE_ASSERT_NEXT(a_busy_after_accept, item.valid && item_ready, !item_ready)
    `DWE_ASSERT_NEXT(a_load_gives_beat, cmd.load, result.valid)
    `DWE_ASSERT_SAME(a_load_needs_room, cmd.load, !result.valid || result.ready)
    `DWE_ASSERT_SAME(a_full_empty_excl, result.valid, !(result.is_full && result.is_empty))
    `DWE_ASSERT_SAME(a_popped_class, result.valid && result.accepted, result.popped_value <= 4'd9)
endmodule

>>> sv/dwe_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module dwe_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

>>> sv/dwe_ctrl.sv
// sequencing state machine of the decision window entropy block
// depends on dwe_pkg for the state and command types
module dwe_ctrl
    import dwe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  dwe_stat_t stat,
    output dwe_cmd_t  cmd
);
    dwe_state_t state_reg;
    dwe_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        item_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready  = 1'b1;
                cmd.capture = item_valid;
                if (item_valid)
                    state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register can take the beat
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

>>> sv/dwe_datapath.sv
// fifo pointers, entry ram, class histogram, term table and output register
// depends on dwe_pkg, dwe_ram
module dwe_datapath
    import dwe_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dwe_cmd_t             cmd,
    output dwe_stat_t            stat,
    input  logic                 in_mode,
    input  logic [CLS_W-1:0]     in_decision,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_accepted,
    output logic [CLS_W-1:0]     out_popped_value,
    output logic [CNT_OUT_W-1:0] out_entry_count,
    output logic                 out_is_full,
    output logic                 out_is_empty,
    output logic [ENT_W-1:0]     out_window_entropy
);
    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] PtrLast  = AW'(DEPTH - 1);
    localparam logic [AW-1:0] CntFull  = AW'(DEPTH - 1);
    localparam logic [63:0]   TermDen  = 64'(DEPTH) << 16;
    localparam logic [63:0]   TermHalf = 64'(DEPTH) << 15;
    localparam logic [63:0]   LogDepth = dwe_log2_q32(32'(DEPTH));

    // entropy term per class count, built at elaboration
    logic [ENT_W-1:0] term_rom [DEPTH];

    for (genvar c = 0; c < DEPTH; c++)
    begin : g_term
        if (c == 0)
        begin : g_zero
            assign term_rom[c] = '0;
        end
        else
        begin : g_val
            localparam logic [63:0] Diff    = LogDepth - dwe_log2_q32(32'(c));
            localparam logic [63:0] TermVal = (64'(c) * Diff + TermHalf) / TermDen;
            assign term_rom[c] = ENT_W'(TermVal);
        end
    end

    logic             mode_reg;
    logic [CLS_W-1:0] dec_reg;
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [AW-1:0]    cnt_reg;
    logic [AW-1:0]    cnt_next;
    logic [AW-1:0]    hist_reg [NUM_CLASSES];
    logic [AW-1:0]    old_cnt_reg;
    logic [AW-1:0]    new_cnt_reg;
    logic             acc_reg;
    logic [CLS_W-1:0] pop_val_reg;
    logic [ENT_W-1:0] term_old_reg;
    logic [ENT_W-1:0] term_new_reg;
    logic [ENT_W-1:0] ent_reg;
    logic [ENT_W-1:0] ent_next;
    logic             out_valid_reg;

    logic [CLS_W-1:0] ram_rdata;
    logic             push_ok;
    logic             pop_ok;
    logic [CLS_W-1:0] cls;
    logic             cls_ok;
    logic [AW-1:0]    old_cnt;
    logic [AW-1:0]    new_cnt;

    dwe_ram #(
        .WIDTH (CLS_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.apply && push_ok),
        .waddr (wr_ptr_reg),
        .wdata (dec_reg),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        push_ok = !mode_reg && (cnt_reg != CntFull) && (dec_reg < CLS_W'(NUM_CLASSES));
        pop_ok  = mode_reg && (cnt_reg != '0);
        // a pop on an empty queue never looks at the ram word
        cls     = pop_ok ? ram_rdata : dec_reg;
        cls_ok  = cls < CLS_W'(NUM_CLASSES);
        old_cnt = cls_ok ? hist_reg[cls] : '0;
        new_cnt = old_cnt;
        if (push_ok)
            new_cnt = old_cnt + 1'b1;
        else if (pop_ok && old_cnt != '0)
            new_cnt = old_cnt - 1'b1;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
            cnt_next    = cnt_reg + 1'b1;
        end
        else if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
            cnt_next    = cnt_reg - 1'b1;
        end
        // only one class count moves per item
        ent_next = ent_reg - term_old_reg + term_new_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= in_mode;
            dec_reg  <= in_decision;
        end
        if (cmd.apply)
        begin
            old_cnt_reg <= old_cnt;
            new_cnt_reg <= new_cnt;
            acc_reg     <= push_ok || pop_ok;
            pop_val_reg <= pop_ok ? ram_rdata : '0;
        end
        if (cmd.lookup)
        begin
            term_old_reg <= term_rom[old_cnt_reg];
            term_new_reg <= term_rom[new_cnt_reg];
        end
        if (cmd.load)
        begin
            out_accepted       <= acc_reg;
            out_popped_value   <= pop_val_reg;
            out_entry_count    <= CNT_OUT_W'(cnt_reg);
            out_is_full        <= (cnt_reg == CntFull);
            out_is_empty       <= (cnt_reg == '0);
            out_window_entropy <= ent_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
            ent_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++)
                hist_reg[i] <= '0;
        end
        else
        begin
            if (cmd.apply)
            begin
                wr_ptr_reg <= wr_ptr_next;
                rd_ptr_reg <= rd_ptr_next;
                cnt_reg    <= cnt_next;
                if (cls_ok)
                    hist_reg[cls] <= new_cnt;
            end
            if (cmd.load)
            begin
                ent_reg       <= ent_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign stat.out_free = !out_valid_reg || out_ready;
endmodule

>>> verif/tb_decision_window_entropy_unit.sv
// testbench for decision_window_entropy_unit: push/pop beats against a queue
// model with class histogram and fixed point entropy table built here
// depends on dwe_pkg, dwe_if and the rtl of the block
module tb_decision_window_entropy_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import dwe_pkg::*;

    localparam int DEPTH       = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 16;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef struct packed {
        logic                 accepted;
        logic [CLS_W-1:0]     popped_value;
        logic [CNT_OUT_W-1:0] entry_count;
        logic                 is_full;
        logic                 is_empty;
        logic [ENT_W-1:0]     window_entropy;
    } window_result_t;

    logic clk;
    logic rst_n;

    dwe_item_if   item_bus ();
    dwe_result_if result_bus ();

    decision_window_entropy_unit #(.DEPTH(DEPTH)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus)
    );

    // queue model state
    logic [CLS_W-1:0] held_decisions[$];
    int unsigned      class_count[NUM_CLASSES];
    int unsigned      term_q16[DEPTH];
    window_result_t   pending_results[$];

    int src_idle_pct;
    int sink_stall_pct;
    int mismatch_count;
    int items_sent;
    int results_checked;
    int pushes_stored;
    int pushes_refused;
    int pops_done;
    int empty_pops;
    int full_hits;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // log2 with 32 fraction bits, mantissa squared once per fraction bit
    function automatic logic [63:0] log2_fix32(input int unsigned x);
        int unsigned whole;
        logic [63:0] mant;
        logic [31:0] frac;
        whole = 0;
        while (whole < 31 && (x >> (whole + 1)) != 0)
            whole++;
        mant = 64'(x) << (30 - whole);
        frac = '0;
        repeat (32)
        begin
            mant = (mant * mant) >> 30;
            frac = frac << 1;
            if (mant >= (64'd1 << 31))
            begin
                frac[0] = 1'b1;
                mant    = mant >> 1;
            end
        end
        return {whole, frac};
    endfunction

    task automatic build_term_table();
        logic [63:0] log_depth;
        logic [63:0] num;
        log_depth   = log2_fix32(DEPTH);
        term_q16[0] = 0;
        for (int c = 1; c < DEPTH; c++)
        begin
            num = 64'(c) * (log_depth - log2_fix32(c)) + (64'(DEPTH) << 15);
            term_q16[c] = int'(num / (64'(DEPTH) << 16));
        end
    endtask

    function automatic window_result_t predict_window(input logic mode,
                                                      input logic [CLS_W-1:0] decision);
        window_result_t r;
        int unsigned    held;
        int unsigned    entropy_sum;
        r = '0;
        if (mode == MODE_PUSH)
        begin
            if (held_decisions.size() < DEPTH - 1 && decision < NUM_CLASSES)
            begin
                held_decisions.push_back(decision);
                class_count[decision]++;
                r.accepted = 1'b1;
                pushes_stored++;
            end
            else
                pushes_refused++;
        end
        else if (held_decisions.size() != 0)
        begin
            r.popped_value = held_decisions.pop_front();
            class_count[r.popped_value]--;
            r.accepted = 1'b1;
            pops_done++;
        end
        else
            empty_pops++;
        held        = held_decisions.size();
        entropy_sum = 0;
        for (int i = 0; i < NUM_CLASSES; i++)
            entropy_sum += term_q16[class_count[i]];
        r.entry_count    = held[CNT_OUT_W-1:0];
        r.is_full        = (held == DEPTH - 1);
        r.is_empty       = (held == 0);
        r.window_entropy = entropy_sum[ENT_W-1:0];
        if (r.is_full && r.accepted)
            full_hits++;
        return r;
    endfunction

    // one beat on the item channel; valid stays up for a back-to-back beat
    task automatic send_beat(input logic mode, input logic [CLS_W-1:0] decision);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid    <= 1'b1;
        item_bus.mode     <= mode;
        item_bus.decision <= decision;
        do
            @(posedge clk);
        while (item_bus.ready !== 1'b1);
        items_sent++;
        pending_results.push_back(predict_window(mode, decision));
    endtask

    task automatic wait_for_results();
        item_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // receiver: checks accepted beats and stalls at random
    initial
    begin
        window_result_t want;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result beat with nothing expected, actual entropy %0d",
                             $time, result_bus.window_entropy);
                end
                else
                begin
                    want = pending_results.pop_front();
                    results_checked++;
                    check_field("accepted", 32'(want.accepted),
                                32'(result_bus.accepted));
                    check_field("popped_value", 32'(want.popped_value),
                                32'(result_bus.popped_value));
                    check_field("entry_count", 32'(want.entry_count),
                                32'(result_bus.entry_count));
                    check_field("is_full", 32'(want.is_full), 32'(result_bus.is_full));
                    check_field("is_empty", 32'(want.is_empty), 32'(result_bus.is_empty));
                    check_field("window_entropy", 32'(want.window_entropy),
                                32'(result_bus.window_entropy));
                end
            end
            result_bus.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // watchdog on cycles with no beat on either channel
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((item_bus.valid === 1'b1 && item_bus.ready === 1'b1) ||
                (result_bus.valid === 1'b1 && result_bus.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, pending_results.size());
                $display("tb_decision_window_entropy_unit failed");
                $finish;
            end
        end
    end

    // every class once, in ascending order
    task automatic test_class_pushes();
        for (int c = 0; c < NUM_CLASSES; c++)
            send_beat(MODE_PUSH, CLS_W'(c));
    endtask

    task automatic test_refused_pushes();
        send_beat(MODE_PUSH, CLS_W'(10));
        send_beat(MODE_PUSH, CLS_W'(15));
    endtask

    // drains what is held, then pops once more on an empty queue
    task automatic test_pop_to_empty();
        int n;
        n = held_decisions.size();
        repeat (n + 1)
            send_beat(MODE_POP, CLS_W'($urandom_range(0, 15)));
    endtask

    // single class up to full, refused pushes at full, then drain
    task automatic test_fill_to_full(input int cls);
        while (held_decisions.size() < DEPTH - 1)
            send_beat(MODE_PUSH, CLS_W'(cls));
        send_beat(MODE_PUSH, CLS_W'($urandom_range(0, NUM_CLASSES - 1)));
        send_beat(MODE_PUSH, CLS_W'($urandom_range(NUM_CLASSES, 15)));
        test_pop_to_empty();
    endtask

    // random walk of the fill level with segments that favour push, favour pop or are balanced
    task automatic test_random_traffic(input int n_items, input int src_pct,
                                       input int sink_pct);
        int sent;
        int seg_left;
        int push_pct;
        int cls_lo;
        int cls_span;
        logic [CLS_W-1:0] decision;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        sent     = 0;
        seg_left = 0;
        push_pct = 50;
        cls_lo   = 0;
        cls_span = NUM_CLASSES - 1;
        while (sent < n_items)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(20, 60);
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 50;
                    default: push_pct = 15;
                endcase
                case ($urandom_range(0, 2))
                    0:
                    begin
                        cls_lo   = 0;
                        cls_span = NUM_CLASSES - 1;
                    end
                    1:
                    begin
                        cls_lo   = $urandom_range(0, NUM_CLASSES - 2);
                        cls_span = 1;
                    end
                    default:
                    begin
                        cls_lo   = $urandom_range(0, NUM_CLASSES - 1);
                        cls_span = 0;
                    end
                endcase
            end
            if ($urandom_range(0, 99) < push_pct)
            begin
                if ($urandom_range(0, 9) == 0)
                    decision = CLS_W'($urandom_range(NUM_CLASSES, 15));
                else
                    decision = CLS_W'(cls_lo + $urandom_range(0, cls_span));
                send_beat(MODE_PUSH, decision);
            end
            else
                send_beat(MODE_POP, CLS_W'($urandom_range(0, 15)));
            sent++;
            seg_left--;
        end
        wait_for_results();
    endtask

    initial
    begin
        mismatch_count  = 0;
        items_sent      = 0;
        results_checked = 0;
        pushes_stored   = 0;
        pushes_refused  = 0;
        pops_done       = 0;
        empty_pops      = 0;
        full_hits       = 0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        for (int i = 0; i < NUM_CLASSES; i++)
            class_count[i] = 0;
        build_term_table();

        rst_n             <= 1'b0;
        item_bus.valid    <= 1'b0;
        item_bus.mode     <= MODE_PUSH;
        item_bus.decision <= '0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_class_pushes();
        test_refused_pushes();
        test_pop_to_empty();
        test_fill_to_full(NUM_CLASSES - 1);
        wait_for_results();

        test_random_traffic(150, 0, 0);
        test_random_traffic(150, 80, 0);
        test_random_traffic(150, 0, 80);
        test_random_traffic(150, 18, 18);

        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (pending_results.size() != 0)
        begin
            mismatch_count++;
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
        end

        $display("sent %0d beats: %0d pushes stored, %0d refused, %0d pops, %0d on empty",
                 items_sent, pushes_stored, pushes_refused, pops_done, empty_pops);
        $display("checked %0d results, queue reached full %0d times, %0d mismatches",
                 results_checked, full_hits, mismatch_count);
        if (mismatch_count == 0)
            $display("tb_decision_window_entropy_unit passed");
        else
            $display("tb_decision_window_entropy_unit failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/dwe_pkg.sv
sv/dwe_if.sv
sv/dwe_ram.sv
sv/dwe_ctrl.sv
sv/dwe_datapath.sv
sv/decision_window_entropy_unit.sv
verif/tb_decision_window_entropy_unit.sv
